>>> hdl/tcc_pkg.sv
package tcc_pkg;

    // Field widths of the input and result beats
    localparam int ACT_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CLASS_W = 3;
    localparam int CELL_W  = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUT_AT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_CUR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

    // Control characters honored by put character
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Color classes and their attributes
    localparam logic [CLASS_W-1:0] CLS_ERROR  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_AUDIO  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_ACCENT = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_DIM    = 3'd4;

    localparam logic [7:0] ATTR_NORMAL = 8'h07;
    localparam logic [7:0] ATTR_ERROR  = 8'h0C;
    localparam logic [7:0] ATTR_AUDIO  = 8'h0E;
    localparam logic [7:0] ATTR_ACCENT = 8'h0B;
    localparam logic [7:0] ATTR_DIM    = 8'h08;

    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_NORMAL, CH_SPACE};

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_res;

    // Map a color class to its attribute byte; unknown classes fall back to normal
    function automatic logic [7:0] f_class_attr(input logic [CLASS_W-1:0] cls);
        logic [7:0] attr;
        unique case (cls)
            CLS_ERROR:  attr = ATTR_ERROR;
            CLS_AUDIO:  attr = ATTR_AUDIO;
            CLS_ACCENT: attr = ATTR_ACCENT;
            CLS_DIM:    attr = ATTR_DIM;
            default:    attr = ATTR_NORMAL;
        endcase
        return attr;
    endfunction

endpackage

>>> hdl/tcc_if.sv
interface tcc_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcc_pkg::ACT_W-1:0]     action;
    logic [tcc_pkg::CHAR_W-1:0]    ch;
    logic [tcc_pkg::COL_W-1:0]     column;
    logic [tcc_pkg::ROW_W-1:0]     line;
    logic [tcc_pkg::CLASS_W-1:0]   color_class;

    modport source (output valid, action, ch, column, line, color_class, input ready);
    modport sink   (input valid, action, ch, column, line, color_class, output ready);
endinterface

interface tcc_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcc_pkg::CHAR_W-1:0]    read_char;
    logic [tcc_pkg::COL_W-1:0]     cursor_col;
    logic [tcc_pkg::ROW_W-1:0]     cursor_row;

    modport source (output valid, read_char, cursor_col, cursor_row, input ready);
    modport sink   (input valid, read_char, cursor_col, cursor_row, output ready);
endinterface

>>> hdl/tcc_ram.sv
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/text_console_cursor_engine.sv
// Channel  | Dir | Beat payload                                 | Handshake
// ---------+-----+----------------------------------------------+------------
// i_in     | in  | action, ch, column, line, color_class        | valid/ready
// o_out    | out | read_char, cursor_col, cursor_row            | valid/ready
// i_cfg_*  | in  | text_color_class (write enable + data)       | we only
//
// Put character, put at coordinate and set cursor complete in the idle state; read
// cell waits for the registered RAM read. Clear screen blanks every cell; newline or
// wrap on the last row adds a scroll, the one write port moving a cell a cycle.
// After reset the block sweeps the screen RAM to blanks with ready low. A result
// beat waits in the output register, and one more in a holding slot, while the
// next item is taken.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcc_in_if.sink                         i_in,
    tcc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [tcc_pkg::CLASS_W-1:0]    i_cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] ADDR_LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] ADDR_COLS   = AW'(COLUMNS);
    localparam logic [AW-1:0] ADDR_BOTTOM = AW'(CELLS - COLUMNS);

    localparam logic [tcc_pkg::COL_W-1:0] COL_LIM  = tcc_pkg::COL_W'(COLUMNS);
    localparam logic [tcc_pkg::COL_W-1:0] COL_LAST = tcc_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcc_pkg::ROW_W-1:0] ROW_LIM  = tcc_pkg::ROW_W'(ROWS);
    localparam logic [tcc_pkg::ROW_W-1:0] ROW_LAST = tcc_pkg::ROW_W'(ROWS - 1);

    // Sequencer states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FILL   = 3'd5;

    logic [2:0]                        r_state, n_state;
    logic [AW-1:0]                     r_ptr, n_ptr;
    logic [tcc_pkg::COL_W-1:0]         r_cx, n_cx;
    logic [tcc_pkg::ROW_W-1:0]         r_cy, n_cy;
    logic [tcc_pkg::CLASS_W-1:0]       r_cls;
    logic                              r_wv, n_wv;
    logic [AW-1:0]                     r_waddr, n_waddr;
    logic                              r_ov, r_pv;
    tcc_pkg::t_res                     r_out, r_p;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [tcc_pkg::CELL_W-1:0]        ram_wdata, ram_rdata;

    logic                              in_ready, accept, out_take, done, wrap, coord_ok;
    logic [tcc_pkg::CHAR_W-1:0]        rd;
    logic [tcc_pkg::CELL_W-1:0]        blank;
    logic [AW-1:0]                     cur_addr, in_addr;
    tcc_pkg::t_res                     res;

    tcc_ram #(
        .WIDTH (tcc_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake and addressing
    assign in_ready = (r_state == ST_IDLE) && !r_pv;
    assign accept   = i_in.valid && in_ready;
    assign out_take = r_ov && o_out.ready;
    assign blank    = {tcc_pkg::f_class_attr(r_cls), tcc_pkg::CH_SPACE};
    assign coord_ok = (i_in.column < COL_LIM) && (i_in.line < ROW_LIM);
    assign cur_addr = AW'(AW'(r_cy) * ADDR_COLS + AW'(r_cx));
    assign in_addr  = AW'(AW'(i_in.line) * ADDR_COLS + AW'(i_in.column));

    // Sequence actions over the screen RAM
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_wv      = 1'b0;
        n_waddr   = r_waddr;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = blank;
        ram_raddr = r_ptr;
        done      = 1'b0;
        wrap      = 1'b0;
        rd        = '0;

        // Finish a row copy issued last cycle
        if (r_wv) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = ram_rdata;
        end

        unique case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = tcc_pkg::RESET_CELL;
                if (r_ptr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    done = 1'b1;
                    unique case (i_in.action)
                        tcc_pkg::ACT_PUT: begin
                            priority if (i_in.ch == tcc_pkg::CH_NL) begin
                                wrap = 1'b1;
                            end else if (i_in.ch == tcc_pkg::CH_CR) begin
                                n_cx = '0;
                            end else if (i_in.ch == tcc_pkg::CH_BS) begin
                                if (r_cx != '0) begin
                                    n_cx = r_cx - 1'b1;
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = {tcc_pkg::f_class_attr(r_cls), i_in.ch};
                                if (r_cx == COL_LAST) begin
                                    wrap = 1'b1;
                                end else begin
                                    n_cx = r_cx + 1'b1;
                                end
                            end
                            // Go to the next row, scrolling from the last one
                            if (wrap) begin
                                n_cx = '0;
                                if (r_cy == ROW_LAST) begin
                                    n_ptr   = ADDR_COLS;
                                    n_state = ST_SCROLL;
                                    done    = 1'b0;
                                end else begin
                                    n_cy = r_cy + 1'b1;
                                end
                            end
                        end
                        tcc_pkg::ACT_PUT_AT: begin
                            if (coord_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = in_addr;
                                ram_wdata = {tcc_pkg::f_class_attr(i_in.color_class), i_in.ch};
                            end
                        end
                        tcc_pkg::ACT_CLEAR: begin
                            n_cx    = '0;
                            n_cy    = '0;
                            n_ptr   = '0;
                            n_state = ST_FILL;
                            done    = 1'b0;
                        end
                        tcc_pkg::ACT_SET_CUR: begin
                            if (i_in.column < COL_LIM) begin
                                n_cx = i_in.column;
                            end
                            if (i_in.line < ROW_LIM) begin
                                n_cy = i_in.line;
                            end
                        end
                        tcc_pkg::ACT_READ: begin
                            if (coord_ok) begin
                                ram_raddr = in_addr;
                                n_state   = ST_READ;
                                done      = 1'b0;
                            end else begin
                                rd = tcc_pkg::CH_SPACE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd      = ram_rdata[tcc_pkg::CHAR_W-1:0];
                done    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read one row down, write back a row up next cycle
                n_wv    = 1'b1;
                n_waddr = r_ptr - ADDR_COLS;
                if (r_ptr == ADDR_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_ptr   = ADDR_BOTTOM;
                n_state = ST_FILL;
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (r_ptr == ADDR_LAST) begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign res = '{read_char: rd, cursor_col: n_cx, cursor_row: n_cy};

    // Advance state, hold results in the output register and the holding slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ptr   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cls   <= '0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_wv    <= n_wv;
            r_waddr <= n_waddr;
            if (i_cfg_we) begin
                r_cls <= i_cfg_wdata;
            end
            priority if (r_pv && (!r_ov || out_take)) begin
                r_out <= r_p;
                r_ov  <= 1'b1;
                r_pv  <= 1'b0;
            end else if (done && (!r_ov || out_take)) begin
                r_out <= res;
                r_ov  <= 1'b1;
            end else if (done) begin
                r_p  <= res;
                r_pv <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.read_char  = r_out.read_char;
    assign o_out.cursor_col = r_out.cursor_col;
    assign o_out.cursor_row = r_out.cursor_row;

endmodule

>>> hdl/tcc_checker.sv
module tcc_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [tcc_pkg::CHAR_W-1:0]     i_read_char,
    input  logic [tcc_pkg::COL_W-1:0]      i_cursor_col,
    input  logic [tcc_pkg::ROW_W-1:0]      i_cursor_row
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_read_char)
            && $stable(i_cursor_col) && $stable(i_cursor_row))
        else $error("result payload changed while stalled");

    // Report a cursor on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cursor_col < tcc_pkg::COL_W'(COLUMNS))
            && (i_cursor_row < tcc_pkg::ROW_W'(ROWS)))
        else $error("cursor off screen");

    // Come out of reset empty and busy with the blanking sweep
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat after reset");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input taken during reset sweep");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_read_char  (o_out.read_char),
    .i_cursor_col (o_out.cursor_col),
    .i_cursor_row (o_out.cursor_row)
);
